FILE: sv/tlrq_pkg.sv
// ---------------------------------------------------------------------------
// tlrq_pkg
// Shared types, constants and helpers of the three-level ready-queue scheduler.
// ---------------------------------------------------------------------------
package tlrq_pkg;

  localparam int unsigned LEVEL_DEPTH_DEF = 16;
  localparam int unsigned ID_BITS_DEF     = 8;

  localparam logic [7:0]  PRIO_L1        = 8'd100;
  localparam logic [7:0]  PRIO_L2        = 8'd50;
  localparam logic [8:0]  PRIO_MAX       = 9'd149;
  localparam logic [7:0]  AGING_STEP_RST = 8'd10;
  localparam logic [15:0] AGING_WAIT_RST = 16'd1500;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W      = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_AGING_STEP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AGING_WAIT = 1'd1;

  // command codes on the input channel
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_PICK   = 2'd1;
  localparam logic [1:0] CMD_AGE    = 2'd2;

  // level codes, level 1 is the most urgent
  localparam logic [1:0] LVL_1 = 2'd0;
  localparam logic [1:0] LVL_2 = 2'd1;
  localparam logic [1:0] LVL_3 = 2'd2;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_PICK,
    OP_AGE,
    OP_NOP
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PICK_RD,
    S_PICK_DATA,
    S_RM_RD,
    S_RM_WR,
    S_INS_CHK,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SH_RD,
    S_SH_WR,
    S_INS_WR,
    S_AGE_CHK,
    S_AGE_DATA,
    S_DONE
  } state_e;

  typedef struct packed {
    op_e         kind;
    logic [1:0]  tgt_lvl;
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] burst;
    logic [31:0] now;
    logic [15:0] running;
  } op_t;

  typedef struct packed {
    logic [5:0] moved;
    logic       dropped;
    logic       preempt;
    logic [1:0] plv;
    logic [7:0] pid;
    logic       found;
  } res_t;

  function automatic logic [1:0] level_of(input logic [7:0] prio);
    logic [1:0] lv;
    if (prio >= PRIO_L1) lv = LVL_1;
    else if (prio >= PRIO_L2) lv = LVL_2;
    else lv = LVL_3;
    return lv;
  endfunction

endpackage

FILE: sv/tlrq_ram.sv
// ---------------------------------------------------------------------------
// tlrq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module tlrq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/tlrq_front.sv
// ---------------------------------------------------------------------------
// tlrq_front
// Accepts commands, decodes them and routes inserts; two-entry command queue.
// ---------------------------------------------------------------------------
module tlrq_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      in_cmd_i,
  input  logic [79:0]     in_data_i,
  output logic            op_valid_o,
  output tlrq_pkg::op_t   op_o,
  input  logic            op_pop_i
);
  import tlrq_pkg::*;

  op_t        slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  op_t        op_new;
  logic       push;

  always_comb begin
    op_new.id      = in_data_i[7:0];
    op_new.prio    = in_data_i[15:8];
    op_new.burst   = in_data_i[31:16];
    op_new.now     = in_data_i[63:32];
    op_new.running = in_data_i[79:64];
    op_new.tgt_lvl = level_of(in_data_i[15:8]);
    case (in_cmd_i)
      CMD_INSERT: op_new.kind = OP_INSERT;
      CMD_PICK:   op_new.kind = OP_PICK;
      CMD_AGE:    op_new.kind = OP_AGE;
      default:    op_new.kind = OP_NOP;
    endcase
  end

  assign in_ready_o = (fill_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign op_valid_o = (fill_q != 2'd0);
  assign op_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= op_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (op_pop_i) rd_ptr_q <= ~rd_ptr_q;
      case ({push, op_pop_i})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

FILE: sv/tlrq_back.sv
// ---------------------------------------------------------------------------
// tlrq_back
// Executes insert, pick and age commands on the three level stores.
// ---------------------------------------------------------------------------
module tlrq_back #(
  parameter int unsigned LEVEL_DEPTH = tlrq_pkg::LEVEL_DEPTH_DEF,
  parameter int unsigned ID_BITS     = tlrq_pkg::ID_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           op_valid_i,
  input  tlrq_pkg::op_t  op_i,
  output logic           op_pop_o,
  input  logic [7:0]     aging_step_i,
  input  logic [15:0]    aging_wait_i,
  output logic           res_valid_o,
  output tlrq_pkg::res_t res_o,
  input  logic           res_ready_i
);
  import tlrq_pkg::*;

  localparam int unsigned AW = $clog2(LEVEL_DEPTH);
  localparam int unsigned CW = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned EW = ID_BITS + 56;

  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_q [3];
  logic [CW-1:0]     cnt_d [3];
  logic [1:0]        lvl_q, lvl_d, tgt_q, tgt_d, age_lv_q, age_lv_d;
  logic              in_age_q, in_age_d;
  logic [CW-1:0]     idx_q, idx_d, j_q, j_d, pos_q, pos_d;
  logic [ID_BITS-1:0] ent_id_q, ent_id_d;
  logic [7:0]        ent_prio_q, ent_prio_d;
  logic [15:0]       ent_burst_q, ent_burst_d;
  logic [31:0]       now_q, now_d;
  logic [15:0]       run_q, run_d;
  res_t              acc_q, acc_d, out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic [AW-1:0]     ram_raddr, ram_waddr;
  logic [EW-1:0]     ram_wdata;
  logic [2:0]        ram_we;
  logic [EW-1:0]     ram_rdata [3];

  logic [EW-1:0]     rd;
  logic [ID_BITS-1:0] rd_id;
  logic [7:0]        rd_prio, np;
  logic [15:0]       rd_burst;
  logic [31:0]       rd_arr, waited;
  logic [8:0]        prio_sum;
  logic [1:0]        np_lvl;
  logic [CW-1:0]     cur_n, j_inc, j_dec;
  logic              ent_first, out_free;
  logic [15:0]       id_ext, rd_id_ext;

  for (genvar g = 0; g < 3; g++) begin : g_lvl
    tlrq_ram #(.WIDTH(EW), .DEPTH(LEVEL_DEPTH)) u_ram (
      .clk_i  (clk_i),
      .we_i   (ram_we[g]),
      .waddr_i(ram_waddr),
      .wdata_i(ram_wdata),
      .raddr_i(ram_raddr),
      .rdata_o(ram_rdata[g])
    );
  end

  assign rd        = ram_rdata[lvl_q];
  assign rd_id     = rd[ID_BITS-1:0];
  assign rd_prio   = rd[ID_BITS+:8];
  assign rd_burst  = rd[ID_BITS+8+:16];
  assign rd_arr    = rd[ID_BITS+24+:32];
  assign waited    = now_q - rd_arr;
  assign prio_sum  = {1'b0, rd_prio} + {1'b0, aging_step_i};
  assign np        = (prio_sum > PRIO_MAX) ? PRIO_MAX[7:0] : prio_sum[7:0];
  assign np_lvl    = level_of(np);
  assign cur_n     = cnt_q[lvl_q];
  assign j_inc     = j_q + 1'b1;
  assign j_dec     = j_q - 1'b1;
  assign id_ext    = {8'd0, op_i.id};
  assign rd_id_ext = 16'(rd_id);
  assign out_free  = !out_valid_q || res_ready_i;

  // new entry goes in front of the stored one; ties favour the higher ID
  always_comb begin
    if (lvl_q == LVL_1 && ent_burst_q != rd_burst) ent_first = ent_burst_q < rd_burst;
    else if (lvl_q != LVL_1 && ent_prio_q != rd_prio) ent_first = ent_prio_q > rd_prio;
    else ent_first = ent_id_q > rd_id;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    lvl_d       = lvl_q;
    tgt_d       = tgt_q;
    age_lv_d    = age_lv_q;
    in_age_d    = in_age_q;
    idx_d       = idx_q;
    j_d         = j_q;
    pos_d       = pos_q;
    ent_id_d    = ent_id_q;
    ent_prio_d  = ent_prio_q;
    ent_burst_d = ent_burst_q;
    now_d       = now_q;
    run_d       = run_q;
    acc_d       = acc_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_ready_i;
    op_pop_o    = 1'b0;
    ram_raddr   = '0;
    ram_waddr   = '0;
    ram_wdata   = rd;
    ram_we      = 3'b000;

    case (state_q)
      S_IDLE: begin
        if (op_valid_i && out_free) begin
          op_pop_o    = 1'b1;
          acc_d       = '0;
          now_d       = op_i.now;
          run_d       = op_i.running;
          ent_id_d    = id_ext[ID_BITS-1:0];
          ent_prio_d  = op_i.prio;
          ent_burst_d = op_i.burst;
          in_age_d    = 1'b0;
          case (op_i.kind)
            OP_INSERT: begin
              lvl_d   = op_i.tgt_lvl;
              state_d = S_INS_CHK;
            end
            OP_PICK: begin
              if (cnt_q[LVL_1] != '0) begin
                lvl_d   = LVL_1;
                state_d = S_PICK_RD;
              end else if (cnt_q[LVL_2] != '0) begin
                lvl_d   = LVL_2;
                state_d = S_PICK_RD;
              end else if (cnt_q[LVL_3] != '0) begin
                lvl_d   = LVL_3;
                state_d = S_PICK_RD;
              end else begin
                state_d = S_DONE;
              end
            end
            OP_AGE: begin
              in_age_d = 1'b1;
              age_lv_d = LVL_2;
              idx_d    = '0;
              state_d  = S_AGE_CHK;
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      S_PICK_RD: begin
        ram_raddr = '0;
        state_d   = S_PICK_DATA;
      end

      S_PICK_DATA: begin
        acc_d.found = 1'b1;
        acc_d.pid   = rd_id_ext[7:0];
        acc_d.plv   = lvl_q;
        j_d         = '0;
        state_d     = S_RM_RD;
      end

      // close the gap: entry j+1 moves down to j
      S_RM_RD: begin
        if (j_inc < cur_n) begin
          ram_raddr = j_inc[AW-1:0];
          state_d   = S_RM_WR;
        end else begin
          cnt_d[lvl_q] = cur_n - 1'b1;
          if (in_age_q) begin
            lvl_d   = tgt_q;
            state_d = S_INS_CHK;
          end else begin
            state_d = S_DONE;
          end
        end
      end

      S_RM_WR: begin
        ram_waddr     = j_q[AW-1:0];
        ram_wdata     = rd;
        ram_we[lvl_q] = 1'b1;
        j_d           = j_inc;
        state_d       = S_RM_RD;
      end

      S_INS_CHK: begin
        if (cur_n >= CW'(LEVEL_DEPTH)) begin
          acc_d.dropped = 1'b1;
          state_d       = in_age_q ? S_AGE_CHK : S_DONE;
        end else if (lvl_q == LVL_3) begin
          pos_d   = cur_n;
          state_d = S_INS_WR;
        end else begin
          j_d     = '0;
          state_d = S_SCAN_RD;
        end
      end

      S_SCAN_RD: begin
        if (j_q == cur_n) begin
          pos_d   = cur_n;
          state_d = S_INS_WR;
        end else begin
          ram_raddr = j_q[AW-1:0];
          state_d   = S_SCAN_CMP;
        end
      end

      S_SCAN_CMP: begin
        if (ent_first) begin
          pos_d   = j_q;
          j_d     = cur_n;
          state_d = S_SH_RD;
        end else begin
          j_d     = j_inc;
          state_d = S_SCAN_RD;
        end
      end

      // open the gap from the tail: entry j-1 moves up to j
      S_SH_RD: begin
        if (j_q > pos_q) begin
          ram_raddr = j_dec[AW-1:0];
          state_d   = S_SH_WR;
        end else begin
          state_d = S_INS_WR;
        end
      end

      S_SH_WR: begin
        ram_waddr     = j_q[AW-1:0];
        ram_wdata     = rd;
        ram_we[lvl_q] = 1'b1;
        j_d           = j_dec;
        state_d       = S_SH_RD;
      end

      S_INS_WR: begin
        ram_waddr     = pos_q[AW-1:0];
        ram_wdata     = {now_q, ent_burst_q, ent_prio_q, ent_id_q};
        ram_we[lvl_q] = 1'b1;
        cnt_d[lvl_q]  = cur_n + 1'b1;
        if (lvl_q == LVL_1 && ent_burst_q < run_q) acc_d.preempt = 1'b1;
        if (in_age_q) begin
          acc_d.moved = acc_q.moved + 6'd1;
          state_d     = S_AGE_CHK;
        end else begin
          state_d = S_DONE;
        end
      end

      S_AGE_CHK: begin
        if (idx_q < cnt_q[age_lv_q]) begin
          ram_raddr = idx_q[AW-1:0];
          lvl_d     = age_lv_q;
          state_d   = S_AGE_DATA;
        end else if (age_lv_q == LVL_2) begin
          age_lv_d = LVL_3;
          idx_d    = '0;
        end else begin
          state_d = S_DONE;
        end
      end

      S_AGE_DATA: begin
        state_d = S_AGE_CHK;
        if (waited >= {16'd0, aging_wait_i}) begin
          if (np_lvl < lvl_q) begin
            // migrate: leave this level, then insert into the higher one
            ent_id_d    = rd_id;
            ent_prio_d  = np;
            ent_burst_d = rd_burst;
            tgt_d       = np_lvl;
            j_d         = idx_q;
            state_d     = S_RM_RD;
          end else begin
            ram_waddr     = idx_q[AW-1:0];
            ram_wdata     = {now_q, rd_burst, np, rd_id};
            ram_we[lvl_q] = 1'b1;
            idx_d         = idx_q + 1'b1;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_DONE: begin
        out_d       = acc_q;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '{default: '0};
      in_age_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      in_age_q    <= in_age_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q       <= lvl_d;
    tgt_q       <= tgt_d;
    age_lv_q    <= age_lv_d;
    idx_q       <= idx_d;
    j_q         <= j_d;
    pos_q       <= pos_d;
    ent_id_q    <= ent_id_d;
    ent_prio_q  <= ent_prio_d;
    ent_burst_q <= ent_burst_d;
    now_q       <= now_d;
    run_q       <= run_d;
    acc_q       <= acc_d;
    out_q       <= out_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

FILE: sv/three_level_ready_queue_scheduler_core.sv
// ---------------------------------------------------------------------------
// three_level_ready_queue_scheduler_core
// Three-level ready-queue scheduler with aging and migration between levels.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream carries commands: tuser is the command (insert, pick, age),
//   tdata the task fields. Each command gives exactly one result transfer on
//   the master stream, in order. Configuration writes (aging step, aging
//   wait) go through the plain write port while the block is idle.
//   A decoder with a two-entry queue takes commands while the execution
//   engine works on an earlier one. The engine steps through a level store
//   one entry at a time, each step a read state and then a write or compare
//   state. An insert into level 1 or 2 scans from the head for its place,
//   shifts the entries behind it up one slot and writes; an insert into
//   level 3 writes at the tail. A pick takes the head of the most urgent
//   non-empty level and moves the rest down. An age visits the tasks in
//   levels 2 and 3, with a removal and an insert for each task that migrates.
//   One command runs at a time, taken only when the output register is free.
//   Reset empties all three levels (fill counts cleared, no RAM sweep) and
//   restores aging step 10 and aging wait 1500. A stalled receiver holds the
//   result in the output register; the queue still fills, then tready drops.
// ---------------------------------------------------------------------------
module three_level_ready_queue_scheduler_core #(
  parameter int unsigned LEVEL_DEPTH = tlrq_pkg::LEVEL_DEPTH_DEF,
  parameter int unsigned ID_BITS     = tlrq_pkg::ID_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // task_id, task_priority, task_burst, now_tick, running_burst
  input  logic [79:0]                    s_axis_tdata,
  // cmd
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // found, picked_id, picked_level, preempt_request, dropped, moved_count, pad
  output logic [23:0]                    m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [tlrq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]                    cfg_wdata_i
);
  import tlrq_pkg::*;

  logic        op_valid, op_pop;
  op_t         op;
  res_t        res;
  logic [7:0]  aging_step_q;
  logic [15:0] aging_wait_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aging_step_q <= AGING_STEP_RST;
      aging_wait_q <= AGING_WAIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_AGING_STEP: aging_step_q <= cfg_wdata_i[7:0];
        CFG_AGING_WAIT: aging_wait_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  tlrq_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .in_cmd_i  (s_axis_tuser),
    .in_data_i (s_axis_tdata),
    .op_valid_o(op_valid),
    .op_o      (op),
    .op_pop_i  (op_pop)
  );

  tlrq_back #(.LEVEL_DEPTH(LEVEL_DEPTH), .ID_BITS(ID_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .op_i        (op),
    .op_pop_o    (op_pop),
    .aging_step_i(aging_step_q),
    .aging_wait_i(aging_wait_q),
    .res_valid_o (m_axis_tvalid),
    .res_o       (res),
    .res_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {5'd0, res};

endmodule

FILE: sv/tlrq_checker.sv
// ---------------------------------------------------------------------------
// tlrq_checker
// Port-level checks on the result stream of the scheduler core.
// ---------------------------------------------------------------------------
module tlrq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  a_rst_quiet: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[10:1] == 10'd0)
    else $error("pick fields set without a found task");

  a_pick_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |->
      m_axis_tdata[18:11] == 8'd0 && m_axis_tdata[10:9] != 2'd3)
    else $error("pick result carries insert or age flags");

endmodule

bind three_level_ready_queue_scheduler_core tlrq_checker u_chk (.*);

FILE: sim/ready_queue_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ready_queue_checker
// Watches the command and result streams of the three-level ready-queue
// scheduler, mirrors its levels, config and timestamps, and compares every
// result transfer field by field with the oldest predicted result.
// ---------------------------------------------------------------------------
module ready_queue_checker
  import tlrq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o,
  output int          picks_o,
  output int          drops_o,
  output int          preempts_o,
  output int          migrations_o
);

  typedef struct {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] burst;
    logic [31:0] arrival;
  } task_entry_t;

  task_entry_t level_mem[3][DEPTH];
  int unsigned level_cnt[3];
  logic [7:0]  step_q;
  logic [15:0] wait_q;
  bit          pre_flag, drop_flag;
  res_t        expected_results[$];
  int          mismatches;

  function automatic int level_for(logic [7:0] p);
    if (p >= PRIO_L1) return 0;
    if (p >= PRIO_L2) return 1;
    return 2;
  endfunction

  function automatic bit goes_before(int lv, task_entry_t a, task_entry_t b);
    if (lv == 0 && a.burst != b.burst) return a.burst < b.burst;
    if (lv != 0 && a.prio != b.prio) return a.prio > b.prio;
    return a.id > b.id;
  endfunction

  function automatic bit place_task(task_entry_t e, logic [31:0] now,
                                    logic [15:0] running);
    int lv;
    int pos;
    int n;
    lv = level_for(e.prio);
    n = level_cnt[lv];
    pos = n;
    e.arrival = now;
    if (n >= DEPTH) begin
      drop_flag = 1'b1;
      return 1'b0;
    end
    if (lv < 2) begin
      for (int i = n - 1; i >= 0; i--)
        if (goes_before(lv, e, level_mem[lv][i])) pos = i;
    end
    for (int i = n; i > pos; i--) level_mem[lv][i] = level_mem[lv][i-1];
    level_mem[lv][pos] = e;
    level_cnt[lv] = n + 1;
    if (lv == 0 && e.burst < running) pre_flag = 1'b1;
    return 1'b1;
  endfunction

  function automatic void remove_at(int lv, int idx);
    for (int i = idx; i < int'(level_cnt[lv]) - 1; i++)
      level_mem[lv][i] = level_mem[lv][i+1];
    level_cnt[lv] = level_cnt[lv] - 1;
  endfunction

  function automatic int age_walk(int lv, logic [31:0] now, logic [15:0] running);
    int moved;
    int i;
    int np;
    logic [31:0] waited;
    task_entry_t e;
    moved = 0;
    i = 0;
    while (i < int'(level_cnt[lv])) begin
      e = level_mem[lv][i];
      waited = now - e.arrival;
      if (waited >= {16'd0, wait_q}) begin
        np = int'(e.prio) + int'(step_q);
        if (np > int'(PRIO_MAX)) np = int'(PRIO_MAX);
        e.prio = np[7:0];
        e.arrival = now;
        if (level_for(e.prio) < lv) begin
          // migrating task leaves first, so a full target loses it
          remove_at(lv, i);
          if (place_task(e, now, running)) moved++;
          continue;
        end
        level_mem[lv][i] = e;
      end
      i++;
    end
    return moved;
  endfunction

  function automatic res_t predict_command(logic [1:0] cmd, logic [79:0] d);
    res_t r;
    task_entry_t e;
    bit stored;
    r = '0;
    pre_flag = 1'b0;
    drop_flag = 1'b0;
    case (cmd)
      CMD_INSERT: begin
        e.id = d[7:0];
        e.prio = d[15:8];
        e.burst = d[31:16];
        e.arrival = d[63:32];
        stored = place_task(e, d[63:32], d[79:64]);
      end
      CMD_PICK: begin
        for (int lv = 0; lv < 3; lv++) begin
          if (level_cnt[lv] > 0) begin
            r.found = 1'b1;
            r.pid = level_mem[lv][0].id;
            r.plv = lv[1:0];
            remove_at(lv, 0);
            break;
          end
        end
      end
      CMD_AGE: begin
        r.moved = 6'(age_walk(1, d[63:32], d[79:64]) + age_walk(2, d[63:32], d[79:64]));
      end
      default: ;
    endcase
    r.preempt = pre_flag;
    r.dropped = drop_flag;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t exp_r;
    if (!rst_ni) begin
      for (int l = 0; l < 3; l++) level_cnt[l] = 0;
      step_q = AGING_STEP_RST;
      wait_q = AGING_WAIT_RST;
      expected_results.delete();
      fail_count_o <= 0;
      results_o <= 0;
      picks_o <= 0;
      drops_o <= 0;
      preempts_o <= 0;
      migrations_o <= 0;
      mismatches = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_AGING_STEP) step_q = cfg_wdata_i[7:0];
        else if (cfg_idx_i == CFG_AGING_WAIT) wait_q = cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(predict_command(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[18:0];
        results_o <= results_o + 1;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result transfer with none expected: %h", got);
        end else begin
          exp_r = expected_results.pop_front();
          picks_o <= picks_o + exp_r.found;
          drops_o <= drops_o + exp_r.dropped;
          preempts_o <= preempts_o + exp_r.preempt;
          migrations_o <= migrations_o + exp_r.moved;
          if (got.found !== exp_r.found || got.pid !== exp_r.pid ||
              got.plv !== exp_r.plv || got.preempt !== exp_r.preempt ||
              got.dropped !== exp_r.dropped || got.moved !== exp_r.moved) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp found %0d id %0d lvl %0d pre %0d drop %0d moved %0d",
                       exp_r.found, exp_r.pid, exp_r.plv, exp_r.preempt, exp_r.dropped,
                       exp_r.moved, "  got found %0d id %0d lvl %0d pre %0d drop %0d moved %0d",
                       got.found, got.pid, got.plv, got.preempt, got.dropped, got.moved);
          end
        end
        fail_count_o <= mismatches;
      end
    end
  end

  assign pending_o = expected_results.size();

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives inserts, picks, ages and no-ops into the ready-queue scheduler with
// random gaps and result stalls, across several aging configurations.
// ---------------------------------------------------------------------------
module testbench;
  import tlrq_pkg::*;

  localparam int CYCLE_LIMIT = 6000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [79:0] s_data = '0;
  logic [1:0]  s_user = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [23:0] m_data;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [15:0] cfg_wdata = '0;

  int fails, pending, n_results, n_picks, n_drops, n_preempts, n_moves;
  int cycles = 0;
  int stall_left = 0;
  bit no_gaps = 0;
  logic [31:0] tick_now;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  three_level_ready_queue_scheduler_core u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
    .s_axis_tdata(s_data), .s_axis_tuser(s_user),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  ready_queue_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
    .s_axis_tdata(s_data), .s_axis_tuser(s_user),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .fail_count_o(fails), .pending_o(pending), .results_o(n_results),
    .picks_o(n_picks), .drops_o(n_drops), .preempts_o(n_preempts),
    .migrations_o(n_moves)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side stalls: a fresh hold-off is drawn after each transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (m_valid && m_ready) begin
        stall_left = no_gaps ? 0 : $urandom_range(0, 6);
        m_ready <= (stall_left == 0);
      end else if (stall_left > 0) begin
        stall_left--;
        m_ready <= (stall_left == 0);
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  task automatic send_cmd(logic [1:0] cmd, logic [7:0] id, logic [7:0] prio,
                          logic [15:0] burst, logic [15:0] running);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user <= cmd;
    s_data <= {running, tick_now, burst, prio, id};
    @(posedge clk);
    while (!s_ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain_all();
    s_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_cmd(int insert_pct, int pick_pct);
    int r;
    logic [1:0]  cmd;
    logic [7:0]  prio;
    logic [15:0] burst;
    logic [7:0]  id;
    r = $urandom_range(0, 99);
    if (r < insert_pct) cmd = CMD_INSERT;
    else if (r < insert_pct + pick_pct) cmd = CMD_PICK;
    else if (r < 97) cmd = CMD_AGE;
    else cmd = 2'd3;
    prio = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, 149));
    burst = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    id = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    if ($urandom_range(0, 19) == 0) tick_now = tick_now + $urandom;
    else tick_now = tick_now + $urandom_range(0, 600);
    send_cmd(cmd, id, prio, burst, 16'($urandom));
  endtask

  initial begin
    logic [7:0]  steps[6];
    logic [15:0] waits[6];
    tick_now = 32'd100;
    steps = '{8'd149, 8'd0, 8'd10, 8'd1, 8'd45, 8'd0};
    waits = '{16'd0, 16'd65535, 16'd1500, 16'd200, 16'd0, 16'd0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pick, thresholds, field extremes, ties, no-op, aging
    send_cmd(CMD_PICK, 8'd0, 8'd0, 16'd0, 16'd0);
    send_cmd(2'd3, 8'hff, 8'hff, 16'hffff, 16'hffff);
    send_cmd(CMD_INSERT, 8'd0, 8'd0, 16'd0, 16'd0);
    send_cmd(CMD_INSERT, 8'd255, 8'd49, 16'hffff, 16'hffff);
    send_cmd(CMD_INSERT, 8'd7, 8'd50, 16'd5, 16'd0);
    send_cmd(CMD_INSERT, 8'd9, 8'd50, 16'd5, 16'd0);
    send_cmd(CMD_INSERT, 8'd3, 8'd99, 16'd1, 16'd0);
    send_cmd(CMD_INSERT, 8'd4, 8'd100, 16'd10, 16'd20);
    send_cmd(CMD_INSERT, 8'd5, 8'd149, 16'd10, 16'd5);
    send_cmd(CMD_INSERT, 8'd6, 8'd255, 16'd0, 16'd1);
    send_cmd(CMD_INSERT, 8'd8, 8'd150, 16'hffff, 16'hffff);
    tick_now = tick_now + 32'd2000;
    send_cmd(CMD_AGE, 8'd0, 8'd0, 16'd0, 16'hffff);
    tick_now = 32'hffff_ff00;
    send_cmd(CMD_AGE, 8'd0, 8'd0, 16'd0, 16'd0);
    repeat (10) send_cmd(CMD_PICK, 8'd0, 8'd0, 16'd0, 16'd0);
    drain_all();

    // one phase per aging setting; the fill-heavy ones overflow levels
    foreach (steps[p]) begin
      write_reg(CFG_AGING_STEP, {8'd0, steps[p]});
      write_reg(CFG_AGING_WAIT, waits[p]);
      no_gaps = (p == 2);
      if (p == 5) tick_now = 32'hffff_f000;
      for (int k = 0; k < 200; k++)
        if (p % 2 == 0) random_cmd(60, 25);
        else random_cmd(45, 40);
      drain_all();
    end
    write_reg(CFG_AGING_STEP, {8'd0, 8'($urandom_range(0, 149))});
    write_reg(CFG_AGING_WAIT, 16'($urandom));
    no_gaps = 0;
    repeat (60) random_cmd(50, 30);
    drain_all();
    repeat (50) @(posedge clk);

    $display("ran %0d commands: %0d picks found, %0d drops, %0d preempt requests, %0d migrations",
             n_results, n_picks, n_drops, n_preempts, n_moves);
    if (fails == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatched results", fails);
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: three_level_ready_queue_scheduler_core.f
sv/tlrq_pkg.sv
sv/tlrq_ram.sv
sv/tlrq_front.sv
sv/tlrq_back.sv
sv/three_level_ready_queue_scheduler_core.sv
sv/tlrq_checker.sv
sim/ready_queue_checker.sv
sim/testbench.sv
